// File: src/bfrd_pkg.sv
// ----------------------------------------------------------------------------
// bfrd_pkg
// Types and constants shared by the block file record deframer.
// ----------------------------------------------------------------------------
package bfrd_pkg;

	typedef enum logic [1:0] {
		KIND_HEADER = 2'd0,
		KIND_END    = 2'd1,
		KIND_SMALL  = 2'd2
	} kind_t;

	// configuration register indexes
	localparam logic CFG_XOR_KEY = 1'b0;
	localparam logic CFG_MAGIC   = 1'b1;

	localparam logic [31:0] MAGIC_RESET = 32'hD9B4_BEF9;
	localparam logic [31:0] HDR_LEN     = 32'd80;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       file_start;
	} in_item_t;

	typedef struct packed {
		kind_t       kind;
		logic [7:0]  header_byte;
		logic        header_last;
		logic [31:0] record_size;
		logic [31:0] record_offset;
	} result_t;

endpackage

// File: src/block_file_record_deframer.sv
// ----------------------------------------------------------------------------
// block_file_record_deframer
// Splits a raw block file byte stream into records and emits the 80 header
// bytes of each record together with its size and file offset.
// ----------------------------------------------------------------------------
// One byte is taken per beat and every beat costs one clock: a byte is held in
// the input register, decoded combinationally against the record counters and
// its result, if any, lands in the output register, so a new byte can enter
// every cycle while the output keeps moving. A result held back by m_tready
// stalls the byte behind it, and the input stalls once that byte is waiting.
// A byte with s_tuser set restarts parsing at offset zero. Marker and size
// bytes and the 80 header bytes are XORed with the key, which restarts at each
// record. A marker mismatch reports end of records and a size below 80 reports
// a short record; both then drop bytes until the next file start. Payload
// bytes past the header give no beat.
module block_file_record_deframer
	import bfrd_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	// configuration
	input  logic        cfg_we,
	input  logic        cfg_index,
	input  logic [63:0] cfg_data,
	// byte input
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // data_byte
	input  logic        s_tuser,   // file_start
	// result output
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [71:0] m_tdata,   // header_byte, record_size, record_offset
	output logic [1:0]  m_tuser,   // result_kind
	output logic        m_tlast    // header_last
);

	logic [63:0] xor_key_q;
	logic [31:0] magic_q;

	logic        running_q;
	logic        in_payload_q;
	logic [31:0] rec_pos_q;
	logic [31:0] size_q;
	logic [31:0] file_pos_q;
	logic [31:0] rec_start_q;

	logic        valid_s1;
	in_item_t    item_s1;

	logic        out_valid_q;
	result_t     out_q;

	logic        adv;
	logic        go;

	// effective state for the byte in stage one
	logic        inp_e;
	logic [31:0] rp_e, sz_e, fp_e, rs_e;
	logic        live;

	logic        run_n, inp_n;
	logic [31:0] rp_n, sz_n, rs_n;
	logic [7:0]  kb, d, mb;
	logic [31:0] sz_acc;

	logic        res_valid;
	result_t     res;

	assign adv      = !out_valid_q || m_tready;
	assign go       = valid_s1 && adv;
	assign s_tready = !valid_s1 || adv;

	always_comb begin
		if (item_s1.file_start) begin
			inp_e = 1'b0;
			rp_e  = '0;
			sz_e  = '0;
			fp_e  = '0;
			rs_e  = '0;
		end else begin
			inp_e = in_payload_q;
			rp_e  = rec_pos_q;
			sz_e  = size_q;
			fp_e  = file_pos_q + 32'd1;
			rs_e  = rec_start_q;
		end
		live = item_s1.file_start || running_q;

		kb     = xor_key_q[{rp_e[2:0], 3'b000} +: 8];
		d      = item_s1.data_byte ^ kb;
		mb     = magic_q[{rp_e[1:0], 3'b000} +: 8];
		sz_acc = ((rp_e[1:0] == 2'd0) ? 32'd0 : sz_e) | ({24'b0, d} << {rp_e[1:0], 3'b000});

		run_n = live;
		inp_n = inp_e;
		rp_n  = rp_e;
		sz_n  = sz_e;
		rs_n  = rs_e;

		res_valid         = 1'b0;
		res.kind          = KIND_HEADER;
		res.header_byte   = '0;
		res.header_last   = 1'b0;
		res.record_size   = '0;
		res.record_offset = rs_e;

		if (live) begin
			if (!inp_e) begin
				if (!rp_e[2]) begin
					// marker bytes
					if (d != mb) begin
						res_valid = 1'b1;
						res.kind  = KIND_END;
						run_n     = 1'b0;
					end else begin
						rp_n = rp_e + 32'd1;
					end
				end else begin
					// little-endian size bytes
					sz_n = sz_acc;
					if (rp_e[1:0] == 2'd3) begin
						if (sz_acc < HDR_LEN) begin
							res_valid       = 1'b1;
							res.kind        = KIND_SMALL;
							res.record_size = sz_acc;
							run_n           = 1'b0;
						end else begin
							inp_n = 1'b1;
							rp_n  = '0;
						end
					end else begin
						rp_n = rp_e + 32'd1;
					end
				end
			end else begin
				if (rp_e < HDR_LEN) begin
					res_valid       = 1'b1;
					res.header_byte = d;
					res.header_last = (rp_e == HDR_LEN - 32'd1);
					res.record_size = sz_e;
				end
				if (rp_e == sz_e - 32'd1) begin
					rs_n  = fp_e + 32'd1;
					inp_n = 1'b0;
					rp_n  = '0;
				end else begin
					rp_n = rp_e + 32'd1;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			xor_key_q <= '0;
			magic_q   <= MAGIC_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_XOR_KEY: xor_key_q <= cfg_data;
				CFG_MAGIC:   magic_q   <= cfg_data[31:0];
				default:     ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			item_s1.data_byte  <= s_tdata;
			item_s1.file_start <= s_tuser;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			running_q    <= 1'b0;
			in_payload_q <= 1'b0;
			rec_pos_q    <= '0;
			size_q       <= '0;
			file_pos_q   <= '0;
			rec_start_q  <= '0;
		end else if (go && live) begin
			running_q    <= run_n;
			in_payload_q <= inp_n;
			rec_pos_q    <= rp_n;
			size_q       <= sz_n;
			file_pos_q   <= fp_e;
			rec_start_q  <= rs_n;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= go && res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (go && res_valid) begin
			out_q <= res;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {out_q.record_offset, out_q.record_size, out_q.header_byte};
	assign m_tuser  = out_q.kind;
	assign m_tlast  = out_q.header_last;

	// an error result always stops parsing
	a_err_stops: assert property (@(posedge clk) disable iff (!arst_n)
		go && res_valid && res.kind != KIND_HEADER |=> !running_q)
		else $error("error result did not stop parsing");

	// payload is only entered with a size that covers the header
	a_payload_size: assert property (@(posedge clk) disable iff (!arst_n)
		in_payload_q |-> size_q >= HDR_LEN)
		else $error("payload entered with short size");

	// header last only on header beats
	a_last_kind: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tlast |-> m_tuser == KIND_HEADER)
		else $error("header last on non-header beat");

	// marker and size prefix never runs past eight bytes
	a_prefix_len: assert property (@(posedge clk) disable iff (!arst_n)
		running_q && !in_payload_q |-> rec_pos_q < 32'd8)
		else $error("prefix position out of range");

endmodule

// File: tb/sv/block_file_record_deframer_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// block_file_record_deframer_tb
// Drives raw block file bytes into the deframer and checks every result beat
// against a cycle-free decoder kept in the bench. Files are built from records
// with a marker, a size and an obfuscated header, mixed with broken markers,
// short sizes and truncated files, under several key and marker settings and
// with random gaps on both the byte input and the result output.
// ----------------------------------------------------------------------------
module block_file_record_deframer_tb;
	import bfrd_pkg::*;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_we = 1'b0;
	logic        cfg_index = CFG_XOR_KEY;
	logic [63:0] cfg_data = '0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [7:0]  s_tdata = '0;    // data_byte
	logic        s_tuser = 1'b0;  // file_start
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [71:0] m_tdata;         // header_byte, record_size, record_offset
	logic [1:0]  m_tuser;         // result_kind
	logic        m_tlast;         // header_last

	block_file_record_deframer dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tuser(s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tuser(m_tuser),
		.m_tlast(m_tlast)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// decoder copy of the block's state and registers
	logic [63:0] key_shadow = '0;
	logic [31:0] magic_shadow = MAGIC_RESET;
	logic        dec_running = 1'b0;
	logic        dec_in_payload = 1'b0;
	logic [31:0] dec_pos = '0;
	logic [31:0] dec_size = '0;
	logic [31:0] dec_file_pos = '0;
	logic [31:0] dec_rec_start = '0;

	result_t pending_results[$];
	int      mismatches = 0;
	int      live_bytes = 0;

	bit tx_gaps = 1'b1;
	bit rx_gaps = 1'b1;
	bit hold_req = 1'b0;
	int hold_len = 0;
	int rx_stall = 0;

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 65)
			return 0;
		else if (r < 92)
			return $urandom_range(1, 3);
		else
			return $urandom_range(8, 40);
	endfunction

	function automatic logic [7:0] key_byte(input int idx);
		return key_shadow[8 * (idx % 8) +: 8];
	endfunction

	task automatic push_result(input kind_t k, input logic [7:0] hb, input logic last,
			input logic [31:0] size, input logic [31:0] offs);
		result_t r;
		r.kind = k;
		r.header_byte = hb;
		r.header_last = last;
		r.record_size = size;
		r.record_offset = offs;
		pending_results.push_back(r);
	endtask

	// works out the result, if any, of one accepted byte
	task automatic decode_byte(input logic [7:0] b, input logic st);
		int p;
		logic [7:0] d;
		bit live;
		live = 1'b1;
		if (st) begin
			dec_running = 1'b1;
			dec_in_payload = 1'b0;
			dec_pos = '0;
			dec_size = '0;
			dec_file_pos = '0;
			dec_rec_start = '0;
		end else if (!dec_running) begin
			live = 1'b0;
		end else begin
			dec_file_pos = dec_file_pos + 32'd1;
		end
		if (live) begin
			live_bytes++;
			if (!dec_in_payload) begin
				p = dec_pos % 8;
				d = b ^ key_byte(p);
				if (p < 4) begin
					if (d != magic_shadow[8 * p +: 8]) begin
						push_result(KIND_END, 8'h00, 1'b0, 32'd0, dec_rec_start);
						dec_running = 1'b0;
					end else begin
						dec_pos = p + 1;
					end
				end else begin
					if (p == 4)
						dec_size = '0;
					dec_size = dec_size | ({24'd0, d} << (8 * (p - 4)));
					if (p == 7) begin
						if (dec_size < HDR_LEN) begin
							push_result(KIND_SMALL, 8'h00, 1'b0, dec_size, dec_rec_start);
							dec_running = 1'b0;
						end else begin
							dec_in_payload = 1'b1;
							dec_pos = '0;
						end
					end else begin
						dec_pos = p + 1;
					end
				end
			end else begin
				if (dec_pos < HDR_LEN)
					push_result(KIND_HEADER, b ^ key_byte(dec_pos + 8),
						dec_pos == HDR_LEN - 1, dec_size, dec_rec_start);
				if (dec_pos == dec_size - 32'd1) begin
					dec_rec_start = dec_file_pos + 32'd1;
					dec_in_payload = 1'b0;
					dec_pos = '0;
				end else begin
					dec_pos = dec_pos + 32'd1;
				end
			end
		end
	endtask

	task automatic send_beat(input logic [7:0] b, input logic st);
		int gap;
		gap = tx_gaps ? pick_gap() : 0;
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= b;
		s_tuser <= st;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		decode_byte(b, st);
	endtask

	// sends the first n_bytes of a record; bad_pos flips a bit of that byte
	task automatic send_record(input bit first, input logic [31:0] size, input int n_bytes,
			input int bad_pos);
		logic [7:0] plain;
		for (int k = 0; k < n_bytes; k++) begin
			if (k < 4)
				plain = magic_shadow[8 * k +: 8];
			else if (k < 8)
				plain = size[8 * (k - 4) +: 8];
			else
				plain = 8'($urandom_range(0, 255));
			if (k == bad_pos)
				plain = plain ^ (8'h01 << $urandom_range(0, 7));
			// key index restarts at each record, marker through header
			if (k < 88)
				plain = plain ^ key_byte(k);
			send_beat(plain, first && k == 0);
		end
	endtask

	task automatic send_junk(input int n);
		repeat (n) send_beat(8'($urandom_range(0, 255)), 1'b0);
	endtask

	task automatic wait_drained();
		s_tvalid <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	task automatic write_reg(input logic idx, input logic [63:0] val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		if (idx == CFG_XOR_KEY)
			key_shadow = val;
		else
			magic_shadow = val[31:0];
		@(posedge clk);
	endtask

	task automatic random_file();
		int nrec, r, sz, bad;
		nrec = $urandom_range(1, 2);
		for (int k = 0; k < nrec; k++) begin
			r = $urandom_range(0, 99);
			sz = (r < 60) ? $urandom_range(80, 100) : $urandom_range(101, 160);
			if (r < 80) begin
				send_record(k == 0, sz, 8 + sz, -1);
			end else if (r < 87) begin
				bad = $urandom_range(0, 3);
				send_record(k == 0, sz, bad + 1, bad);
				send_junk($urandom_range(0, 4));
				break;
			end else if (r < 93) begin
				send_record(k == 0, $urandom_range(0, 79), 8, -1);
				send_junk($urandom_range(0, 4));
				break;
			end else begin
				// huge size, file ends inside the record
				send_record(k == 0, $urandom | 32'h0000_0100, $urandom_range(1, 110), -1);
				break;
			end
		end
	endtask

	task automatic test_random_files(input int budget);
		int base;
		base = live_bytes;
		while (live_bytes - base < budget) random_file();
	endtask

	task automatic test_idle_bytes();
		send_junk(3);
	endtask

	task automatic test_marker_mismatch();
		for (int pos = 0; pos < 4; pos++)
			send_record(1'b1, 32'd100, pos + 1, pos);
	endtask

	task automatic test_short_size();
		send_record(1'b1, 32'd79, 8, -1);
		send_record(1'b1, 32'd0, 8, -1);
	endtask

	// exact header-sized record, then one byte over in the same file
	task automatic test_record_boundaries();
		send_record(1'b1, 32'd80, 88, -1);
		send_record(1'b0, 32'd81, 89, -1);
	endtask

	task automatic test_stalled_output();
		hold_len = 300;
		hold_req = 1'b1;
		tx_gaps = 1'b0;
		send_record(1'b1, 32'd90, 98, -1);
		tx_gaps = 1'b1;
		wait_drained();
	endtask

	task automatic test_full_rate();
		tx_gaps = 1'b0;
		rx_gaps = 1'b0;
		send_record(1'b1, 32'd84, 92, -1);
		tx_gaps = 1'b1;
		rx_gaps = 1'b1;
		wait_drained();
	endtask

	// result side: random stalls, or one long hold when asked
	initial begin
		forever begin
			@(posedge clk);
			if (hold_req) begin
				rx_stall = hold_len;
				hold_req = 1'b0;
			end
			if (rx_stall > 0) begin
				m_tready <= 1'b0;
				rx_stall--;
			end else begin
				m_tready <= 1'b1;
				if (rx_gaps)
					rx_stall = pick_gap();
			end
		end
	end

	always @(posedge clk) begin : check_results
		result_t got, want;
		if (arst_n && m_tvalid && m_tready) begin
			got.kind = kind_t'(m_tuser);
			got.header_byte = m_tdata[7:0];
			got.header_last = m_tlast;
			got.record_size = m_tdata[39:8];
			got.record_offset = m_tdata[71:40];
			if (pending_results.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected beat: kind %0d byte %02h last %0b size %0d offset %0d",
						got.kind, got.header_byte, got.header_last, got.record_size,
						got.record_offset);
			end else begin
				want = pending_results.pop_front();
				if (got.kind !== want.kind || got.header_byte !== want.header_byte ||
						got.header_last !== want.header_last ||
						got.record_size !== want.record_size ||
						got.record_offset !== want.record_offset) begin
					mismatches++;
					if (mismatches <= 10) begin
						$display("mismatch at %0t ns", $time);
						$display("  expected kind %0d byte %02h last %0b size %0d offset %0d",
							want.kind, want.header_byte, want.header_last,
							want.record_size, want.record_offset);
						$display("  actual   kind %0d byte %02h last %0b size %0d offset %0d",
							got.kind, got.header_byte, got.header_last,
							got.record_size, got.record_offset);
					end
				end
			end
		end
	end

	initial begin
		#2_000_000;
		$display("block_file_record_deframer verification failed");
		$finish;
	end

	initial begin
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);
		test_idle_bytes();
		test_marker_mismatch();
		test_short_size();
		test_record_boundaries();
		test_random_files(40);
		wait_drained();
		write_reg(CFG_XOR_KEY, {$urandom, $urandom});
		test_stalled_output();
		write_reg(CFG_XOR_KEY, '1);
		write_reg(CFG_MAGIC, 64'h0);
		test_full_rate();
		write_reg(CFG_XOR_KEY, 64'h0);
		write_reg(CFG_MAGIC, 64'hFFFF_FFFF);
		test_random_files(40);
		wait_drained();
		write_reg(CFG_XOR_KEY, {$urandom, $urandom});
		write_reg(CFG_MAGIC, {32'h0, $urandom});
		test_random_files(40);
		wait_drained();
		repeat (20) @(posedge clk);
		if (mismatches == 0 && pending_results.size() == 0)
			$display("block_file_record_deframer verification clean");
		else
			$display("block_file_record_deframer verification failed");
		$finish;
	end

endmodule
